/* rtl/b3o_pkg.sv */
`default_nettype none
package b3o_pkg;

  localparam int INDEX_BITS_DEF   = 32;
  localparam int MAX_GRID_DIM_DEF = 1024;
  localparam int MAX_LAYERS_DEF   = 256;

  localparam int DATA_W  = 32;
  localparam int GRID_W  = 11;
  localparam int LAYER_W = 9;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_ROWS  = 3'd0,
    CFG_TOTAL_COLS  = 3'd1,
    CFG_GRID_ROWS   = 3'd2,
    CFG_GRID_COLS   = 3'd3,
    CFG_GRID_LAYERS = 3'd4,
    CFG_SPLIT_COL   = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_DIV_M,
    ST_DIV_N,
    ST_MUL_B,
    ST_DIV_SM,
    ST_DIV_SL,
    ST_MUL_L,
    ST_DONE
  } setup_st_t;

  typedef struct packed {
    logic [31:0] global_row;
    logic [31:0] global_col;
  } in_t;

  typedef struct packed {
    logic [7:0]  owner_layer;
    logic [9:0]  owner_grid_row;
    logic [9:0]  owner_grid_col;
    logic [31:0] local_row;
    logic [31:0] local_col;
  } out_t;

  typedef struct packed {
    logic              ready;
    logic              split;
    logic [GRID_W-1:0] pr_m1;
    logic [GRID_W-1:0] pc_m1;
    logic [LAYER_W-1:0] nl_m1;
    logic [DATA_W-1:0] m_share;
    logic [DATA_W-1:0] n_share;
    logic [DATA_W-1:0] base_r;
    logic [DATA_W-1:0] base_c;
    logic [DATA_W-1:0] s_mid;
    logic [DATA_W-1:0] s_last;
    logic [DATA_W-1:0] lb_mid;
    logic [DATA_W-1:0] lb_last;
  } setup_t;

endpackage
`default_nettype wire

/* rtl/b3o_div_cell.sv */
`default_nettype none
// One restoring division step: one quotient bit per cell, MSB first.
module b3o_div_cell #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] div_i,
  input  wire logic [W-1:0] rem_i,
  input  wire logic [W-1:0] num_i,
  input  wire logic [W-1:0] quo_i,
  input  wire logic [W-1:0] org_i,
  output logic      [W-1:0] rem_o,
  output logic      [W-1:0] num_o,
  output logic      [W-1:0] quo_o,
  output logic      [W-1:0] org_o
);

  logic [W:0]   trial;
  logic         ge;
  logic [W-1:0] rem_nxt, num_nxt, quo_nxt;
  logic [W-1:0] rem_r, num_r, quo_r, org_r;

  always_comb begin
    trial   = {rem_i, num_i[W-1]};
    ge      = (trial >= {1'b0, div_i});
    rem_nxt = ge ? W'(trial - {1'b0, div_i}) : trial[W-1:0];
    num_nxt = {num_i[W-2:0], 1'b0};
    quo_nxt = {quo_i[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      quo_r <= quo_nxt;
      org_r <= org_i;
    end
  end

  assign rem_o = rem_r;
  assign num_o = num_r;
  assign quo_o = quo_r;
  assign org_o = org_r;

endmodule
`default_nettype wire

/* rtl/b3o_setup.sv */
`default_nettype none
// Config registers plus the per-config shares, worked out by a serial divider.
module b3o_setup #(
  parameter int INDEX_BITS   = b3o_pkg::INDEX_BITS_DEF,
  parameter int MAX_GRID_DIM = b3o_pkg::MAX_GRID_DIM_DEF,
  parameter int MAX_LAYERS   = b3o_pkg::MAX_LAYERS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  input  wire logic [b3o_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data,
  output b3o_pkg::setup_t                     setup
);

  localparam int W  = (INDEX_BITS < 32) ? INDEX_BITS : 32;
  localparam int CW = $clog2(W);
  localparam int GW = b3o_pkg::GRID_W;
  localparam int LW = b3o_pkg::LAYER_W;

  logic [31:0]   total_rows_r, total_cols_r;
  logic [GW-1:0] grid_rows_r, grid_cols_r;
  logic [LW-1:0] grid_layers_r;
  logic          split_r;

  b3o_pkg::setup_st_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, num_r, quo_r;
  logic [W-1:0]  rem_nxt, num_nxt, quo_nxt;
  logic [W-1:0]  m_share_r, n_share_r, base_r_r, base_c_r;
  logic [W-1:0]  s_mid_r, s_last_r, lb_mid_r, lb_last_r;

  logic [GW-1:0] pr, pc;
  logic [LW-1:0] nl;
  logic [W-1:0]  tm, tn, op_n, op_d, cur_n, cur_r, cur_q;
  logic [W:0]    trial;
  logic          ge, is_div, last_bit;

  always_comb begin
    if (grid_rows_r == '0) pr = GW'(1);
    else if (32'(grid_rows_r) > 32'(MAX_GRID_DIM)) pr = GW'(MAX_GRID_DIM);
    else pr = grid_rows_r;
    if (grid_cols_r == '0) pc = GW'(1);
    else if (32'(grid_cols_r) > 32'(MAX_GRID_DIM)) pc = GW'(MAX_GRID_DIM);
    else pc = grid_cols_r;
    if (grid_layers_r == '0) nl = LW'(1);
    else if (32'(grid_layers_r) > 32'(MAX_LAYERS)) nl = LW'(MAX_LAYERS);
    else nl = grid_layers_r;
    tm = total_rows_r[W-1:0];
    tn = total_cols_r[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_rows_r  <= 32'd1;
      total_cols_r  <= 32'd1;
      grid_rows_r   <= GW'(1);
      grid_cols_r   <= GW'(1);
      grid_layers_r <= LW'(1);
      split_r       <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        b3o_pkg::CFG_TOTAL_ROWS:  total_rows_r  <= cfg_data;
        b3o_pkg::CFG_TOTAL_COLS:  total_cols_r  <= cfg_data;
        b3o_pkg::CFG_GRID_ROWS:   grid_rows_r   <= cfg_data[GW-1:0];
        b3o_pkg::CFG_GRID_COLS:   grid_cols_r   <= cfg_data[GW-1:0];
        b3o_pkg::CFG_GRID_LAYERS: grid_layers_r <= cfg_data[LW-1:0];
        b3o_pkg::CFG_SPLIT_COL:   split_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // operand select for the shared divider
  always_comb begin
    op_n = tm;
    op_d = W'(pr);
    case (st_r)
      b3o_pkg::ST_DIV_M: begin
        op_n = tm;
        op_d = W'(pr);
      end
      b3o_pkg::ST_DIV_N: begin
        op_n = tn;
        op_d = W'(pc);
      end
      b3o_pkg::ST_DIV_SM: begin
        op_n = split_r ? n_share_r : m_share_r;
        op_d = W'(nl);
      end
      b3o_pkg::ST_DIV_SL: begin
        op_n = split_r ? W'(tn - base_c_r) : W'(tm - base_r_r);
        op_d = W'(nl);
      end
      default: ;
    endcase
    is_div   = (st_r == b3o_pkg::ST_DIV_M) || (st_r == b3o_pkg::ST_DIV_N) ||
               (st_r == b3o_pkg::ST_DIV_SM) || (st_r == b3o_pkg::ST_DIV_SL);
    last_bit = (cnt_r == CW'(W - 1));
    cur_n    = (cnt_r == '0) ? op_n : num_r;
    cur_r    = (cnt_r == '0) ? '0 : rem_r;
    cur_q    = (cnt_r == '0) ? '0 : quo_r;
    trial    = {cur_r, cur_n[W-1]};
    ge       = (trial >= {1'b0, op_d});
    rem_nxt  = ge ? W'(trial - {1'b0, op_d}) : trial[W-1:0];
    num_nxt  = {cur_n[W-2:0], 1'b0};
    quo_nxt  = {cur_q[W-2:0], ge};
    cnt_nxt  = (is_div && !last_bit) ? CW'(cnt_r + 1'b1) : '0;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      b3o_pkg::ST_DIV_M:  if (last_bit) st_nxt = b3o_pkg::ST_DIV_N;
      b3o_pkg::ST_DIV_N:  if (last_bit) st_nxt = b3o_pkg::ST_MUL_B;
      b3o_pkg::ST_MUL_B:  st_nxt = b3o_pkg::ST_DIV_SM;
      b3o_pkg::ST_DIV_SM: if (last_bit) st_nxt = b3o_pkg::ST_DIV_SL;
      b3o_pkg::ST_DIV_SL: if (last_bit) st_nxt = b3o_pkg::ST_MUL_L;
      b3o_pkg::ST_MUL_L:  st_nxt = b3o_pkg::ST_DONE;
      b3o_pkg::ST_DONE:   st_nxt = b3o_pkg::ST_DONE;
      default:            st_nxt = b3o_pkg::ST_DIV_M;
    endcase
    if (cfg_valid) st_nxt = b3o_pkg::ST_DIV_M;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= b3o_pkg::ST_DIV_M;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cfg_valid ? '0 : cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    if (last_bit && st_r == b3o_pkg::ST_DIV_M)  m_share_r <= quo_nxt;
    if (last_bit && st_r == b3o_pkg::ST_DIV_N)  n_share_r <= quo_nxt;
    if (last_bit && st_r == b3o_pkg::ST_DIV_SM) s_mid_r   <= quo_nxt;
    if (last_bit && st_r == b3o_pkg::ST_DIV_SL) s_last_r  <= quo_nxt;
    if (st_r == b3o_pkg::ST_MUL_B) begin
      base_r_r <= W'(m_share_r * W'(pr - 1'b1));
      base_c_r <= W'(n_share_r * W'(pc - 1'b1));
    end
    if (st_r == b3o_pkg::ST_MUL_L) begin
      lb_mid_r  <= W'(s_mid_r * W'(nl - 1'b1));
      lb_last_r <= W'(s_last_r * W'(nl - 1'b1));
    end
  end

  always_comb begin
    setup.ready   = (st_r == b3o_pkg::ST_DONE);
    setup.split   = split_r;
    setup.pr_m1   = GW'(pr - 1'b1);
    setup.pc_m1   = GW'(pc - 1'b1);
    setup.nl_m1   = LW'(nl - 1'b1);
    setup.m_share = 32'(m_share_r);
    setup.n_share = 32'(n_share_r);
    setup.base_r  = 32'(base_r_r);
    setup.base_c  = 32'(base_c_r);
    setup.s_mid   = 32'(s_mid_r);
    setup.s_last  = 32'(s_last_r);
    setup.lb_mid  = 32'(lb_mid_r);
    setup.lb_last = 32'(lb_last_r);
  end

endmodule
`default_nettype wire

/* rtl/block_3d_owner_index.sv */
`default_nettype none
// Owner lookup for a block-distributed matrix on a 3D process grid. Takes one
// request per cycle while in_ready is high; each result passes through two
// chains of W restoring-division cells (W = datapath width, 32 by default):
// the first finds grid row and column, the second the layer. After reset and
// after every config write, a serial divider recomputes the per-process
// shares; in_ready stays low meanwhile. Config writes are always taken and
// belong to idle periods only.
module block_3d_owner_index #(
  parameter int INDEX_BITS   = b3o_pkg::INDEX_BITS_DEF,
  parameter int MAX_GRID_DIM = b3o_pkg::MAX_GRID_DIM_DEF,
  parameter int MAX_LAYERS   = b3o_pkg::MAX_LAYERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire b3o_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output b3o_pkg::out_t                      out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [b3o_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  localparam int W  = (INDEX_BITS < 32) ? INDEX_BITS : 32;
  localparam int GW = b3o_pkg::GRID_W;
  localparam int LW = b3o_pkg::LAYER_W;
  localparam int NV = 2 * W + 2;

  typedef struct packed {
    logic [GW-1:0] prow;
    logic [GW-1:0] pcol;
    logic [W-1:0]  other;
    logic [W-1:0]  div;
    logic [W-1:0]  lbase;
  } side_t;

  b3o_pkg::setup_t setup;
  logic            adv;
  logic [NV-1:0]   vld_r;

  b3o_setup #(
    .INDEX_BITS  (INDEX_BITS),
    .MAX_GRID_DIM(MAX_GRID_DIM),
    .MAX_LAYERS  (MAX_LAYERS)
  ) u_setup (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .setup    (setup)
  );

  assign cfg_ready = 1'b1;
  assign adv       = !vld_r[NV-1] || out_ready;
  assign in_ready  = adv && setup.ready;
  assign out_valid = vld_r[NV-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], in_valid && setup.ready};
    end
  end

  // row/column chain
  logic [W-1:0] rr[W+1], rn[W+1], rq[W+1], ro[W+1];
  logic [W-1:0] cr[W+1], cn[W+1], cq[W+1], co[W+1];

  assign rr[0] = '0;
  assign rn[0] = in_data.global_row[W-1:0];
  assign rq[0] = '0;
  assign ro[0] = in_data.global_row[W-1:0];
  assign cr[0] = '0;
  assign cn[0] = in_data.global_col[W-1:0];
  assign cq[0] = '0;
  assign co[0] = in_data.global_col[W-1:0];

  for (genvar k = 0; k < W; k++) begin : g_rc
    b3o_div_cell #(.W(W)) u_row (
      .clk(clk), .en(adv), .div_i(setup.m_share[W-1:0]),
      .rem_i(rr[k]), .num_i(rn[k]), .quo_i(rq[k]), .org_i(ro[k]),
      .rem_o(rr[k+1]), .num_o(rn[k+1]), .quo_o(rq[k+1]), .org_o(ro[k+1])
    );
    b3o_div_cell #(.W(W)) u_col (
      .clk(clk), .en(adv), .div_i(setup.n_share[W-1:0]),
      .rem_i(cr[k]), .num_i(cn[k]), .quo_i(cq[k]), .org_i(co[k]),
      .rem_o(cr[k+1]), .num_o(cn[k+1]), .quo_o(cq[k+1]), .org_o(co[k+1])
    );
  end

  // clamp block indices, pick the layer split dimension
  logic          rclamp, cclamp, last_blk;
  logic [GW-1:0] prow, pcol;
  logic [W-1:0]  lrow, lcol;
  logic [W-1:0]  mid_num_r;
  side_t         mid_sd_r;

  always_comb begin
    rclamp   = (rq[W] >= W'(setup.pr_m1));
    cclamp   = (cq[W] >= W'(setup.pc_m1));
    prow     = rclamp ? setup.pr_m1 : rq[W][GW-1:0];
    pcol     = cclamp ? setup.pc_m1 : cq[W][GW-1:0];
    lrow     = rclamp ? W'(ro[W] - setup.base_r[W-1:0]) : rr[W];
    lcol     = cclamp ? W'(co[W] - setup.base_c[W-1:0]) : cr[W];
    last_blk = setup.split ? (pcol == setup.pc_m1) : (prow == setup.pr_m1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_num_r      <= setup.split ? lcol : lrow;
      mid_sd_r.prow  <= prow;
      mid_sd_r.pcol  <= pcol;
      mid_sd_r.other <= setup.split ? lrow : lcol;
      mid_sd_r.div   <= last_blk ? setup.s_last[W-1:0] : setup.s_mid[W-1:0];
      mid_sd_r.lbase <= last_blk ? setup.lb_last[W-1:0] : setup.lb_mid[W-1:0];
    end
  end

  // layer chain
  logic [W-1:0] lr[W+1], ln[W+1], lq[W+1], lo[W+1];
  side_t        sd[W+1];

  assign lr[0] = '0;
  assign ln[0] = mid_num_r;
  assign lq[0] = '0;
  assign lo[0] = mid_num_r;
  assign sd[0] = mid_sd_r;

  for (genvar k = 0; k < W; k++) begin : g_ly
    side_t sd_r;
    b3o_div_cell #(.W(W)) u_lay (
      .clk(clk), .en(adv), .div_i(sd[k].div),
      .rem_i(lr[k]), .num_i(ln[k]), .quo_i(lq[k]), .org_i(lo[k]),
      .rem_o(lr[k+1]), .num_o(ln[k+1]), .quo_o(lq[k+1]), .org_o(lo[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) sd_r <= sd[k];
    end
    assign sd[k+1] = sd_r;
  end

  logic          lclamp;
  logic [LW-1:0] layer;
  logic [W-1:0]  lloc;
  b3o_pkg::out_t out_r;

  always_comb begin
    lclamp = (lq[W] >= W'(setup.nl_m1));
    layer  = lclamp ? setup.nl_m1 : lq[W][LW-1:0];
    lloc   = lclamp ? W'(lo[W] - sd[W].lbase) : lr[W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.owner_layer    <= layer[7:0];
      out_r.owner_grid_row <= sd[W].prow[9:0];
      out_r.owner_grid_col <= sd[W].pcol[9:0];
      out_r.local_row      <= 32'(setup.split ? sd[W].other : lloc);
      out_r.local_col      <= 32'(setup.split ? lloc : sd[W].other);
    end
  end

  assign out_data = out_r;

  a_accept_needs_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> setup.ready)
    else $error("request accepted before shares were ready");

  a_cfg_restarts_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> !in_ready)
    else $error("config write did not restart share computation");

  a_stall_freezes_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && !out_ready) |-> $stable(vld_r))
    else $error("pipeline moved while output stalled");

endmodule
`default_nettype wire
